### hw/rtl/clr_pkg.sv
// clr_pkg: shared types and constants for the clipped line rasterizer
// payload structs for the command and result channels, the pixel info struct
// passed from the stepping core to the top level, and the command codes

package clr_pkg;

    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int RGB_W      = 3 * COLOR_W;
    localparam int ADDR_W     = 24;
    localparam int HEIGHT_W   = 13;
    // wide enough to hold MAX_HEIGHT at its top value
    localparam int HEIGHT_EXT_W = HEIGHT_W + 1;
    localparam int DX_W       = COORD_W + 1;
    localparam int NDY_W      = COORD_W + 2;
    localparam int ERR_W      = COORD_W + 3;

    localparam int FRAME_WIDTH_DEF     = 1024;
    localparam int BYTES_PER_PIXEL_DEF = 3;
    localparam int MAX_HEIGHT_DEF      = 4096;

    localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(1024);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0]        color_red;
        logic [COLOR_W-1:0]        color_green;
        logic [COLOR_W-1:0]        color_blue;
    } t_in;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  byte_address;
        logic [COLOR_W-1:0] pixel_red;
        logic [COLOR_W-1:0] pixel_green;
        logic [COLOR_W-1:0] pixel_blue;
        logic               last_pixel;
        logic               idle;
    } t_out;

    // current pixel of an active line, as seen by a step command
    typedef struct packed {
        logic                      drawing;
        logic                      last;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RGB_W-1:0]          color;
    } t_pix;

endpackage

### hw/rtl/clr_core.sv
// clr_core: line state registers and the Bresenham setup and step update
// uses clr_pkg for the command struct, the pixel info struct and command codes

module clr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  clr_pkg::t_in   i_item,
    output clr_pkg::t_pix  o_pix
);

    logic signed [clr_pkg::COORD_W-1:0] r_cur_x, n_cur_x;
    logic signed [clr_pkg::COORD_W-1:0] r_cur_y, n_cur_y;
    logic signed [clr_pkg::COORD_W-1:0] r_tgt_x, n_tgt_x;
    logic signed [clr_pkg::COORD_W-1:0] r_tgt_y, n_tgt_y;
    logic signed [clr_pkg::DX_W-1:0]    r_dx, n_dx;
    logic signed [clr_pkg::NDY_W-1:0]   r_ndy, n_ndy;
    logic signed [clr_pkg::ERR_W-1:0]   r_err, n_err;
    logic                               r_sx_neg, n_sx_neg;
    logic                               r_sy_neg, n_sy_neg;
    logic [clr_pkg::RGB_W-1:0]          r_color, n_color;
    logic                               r_active, n_active;

    // load setup
    logic signed [clr_pkg::DX_W-1:0]    diff_x, diff_y, abs_x, abs_y;
    logic signed [clr_pkg::NDY_W-1:0]   ld_ndy;
    logic                               x_up, y_up;
    // step update
    logic signed [clr_pkg::ERR_W:0]     e2;
    logic                               move_x, move_y, at_end;
    logic signed [clr_pkg::ERR_W-1:0]   add_x, add_y;

    always_comb begin
        diff_x = clr_pkg::DX_W'(i_item.end_x) - clr_pkg::DX_W'(i_item.start_x);
        diff_y = clr_pkg::DX_W'(i_item.end_y) - clr_pkg::DX_W'(i_item.start_y);
        x_up   = i_item.end_x > i_item.start_x;
        y_up   = i_item.end_y > i_item.start_y;
        abs_x  = x_up ? diff_x : -diff_x;
        abs_y  = y_up ? diff_y : -diff_y;
        ld_ndy = -clr_pkg::NDY_W'(abs_y);

        e2     = {r_err, 1'b0};
        at_end = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
        move_x = e2 >= (clr_pkg::ERR_W+1)'(r_ndy);
        move_y = e2 <= (clr_pkg::ERR_W+1)'(r_dx);
        add_x  = move_x ? clr_pkg::ERR_W'(r_ndy) : '0;
        add_y  = move_y ? clr_pkg::ERR_W'(r_dx) : '0;
    end

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_tgt_x  = r_tgt_x;
        n_tgt_y  = r_tgt_y;
        n_dx     = r_dx;
        n_ndy    = r_ndy;
        n_err    = r_err;
        n_sx_neg = r_sx_neg;
        n_sy_neg = r_sy_neg;
        n_color  = r_color;
        n_active = r_active;
        if (i_accept && i_item.command == clr_pkg::CMD_LOAD) begin
            n_cur_x  = i_item.start_x;
            n_cur_y  = i_item.start_y;
            n_tgt_x  = i_item.end_x;
            n_tgt_y  = i_item.end_y;
            n_dx     = abs_x;
            n_ndy    = ld_ndy;
            n_err    = clr_pkg::ERR_W'(abs_x) + clr_pkg::ERR_W'(ld_ndy);
            n_sx_neg = !x_up;
            n_sy_neg = !y_up;
            n_color  = {i_item.color_red, i_item.color_green, i_item.color_blue};
            n_active = 1'b1;
        end else if (i_accept && r_active) begin
            if (at_end) begin
                n_active = 1'b0;
            end else begin
                n_err = r_err + add_x + add_y;
                if (move_x) begin
                    n_cur_x = r_sx_neg ? r_cur_x - 16'sd1 : r_cur_x + 16'sd1;
                end
                if (move_y) begin
                    n_cur_y = r_sy_neg ? r_cur_y - 16'sd1 : r_cur_y + 16'sd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_dx     <= '0;
            r_ndy    <= '0;
            r_err    <= '0;
            r_sx_neg <= 1'b0;
            r_sy_neg <= 1'b0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_tgt_x  <= n_tgt_x;
            r_tgt_y  <= n_tgt_y;
            r_dx     <= n_dx;
            r_ndy    <= n_ndy;
            r_err    <= n_err;
            r_sx_neg <= n_sx_neg;
            r_sy_neg <= n_sy_neg;
            r_color  <= n_color;
            r_active <= n_active;
        end
    end

    always_comb begin
        o_pix.drawing = (i_item.command == clr_pkg::CMD_STEP) && r_active;
        o_pix.last    = at_end;
        o_pix.x       = r_cur_x;
        o_pix.y       = r_cur_y;
        o_pix.color   = r_color;
    end

endmodule

### hw/rtl/clr_pixel_addr.sv
// clr_pixel_addr: frame clipping test and byte address of one pixel
// uses clr_pkg for coordinate, height and address widths

module clr_pixel_addr #(
    parameter int FRAME_WIDTH     = clr_pkg::FRAME_WIDTH_DEF,
    parameter int BYTES_PER_PIXEL = clr_pkg::BYTES_PER_PIXEL_DEF,
    parameter int MAX_HEIGHT      = clr_pkg::MAX_HEIGHT_DEF
) (
    input  logic signed [clr_pkg::COORD_W-1:0] i_x,
    input  logic signed [clr_pkg::COORD_W-1:0] i_y,
    input  logic [clr_pkg::HEIGHT_W-1:0]       i_height,
    output logic                               o_inside,
    output logic [clr_pkg::ADDR_W-1:0]         o_addr
);

    localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_W     = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int ROW_BYTES = FRAME_WIDTH * BYTES_PER_PIXEL;
    localparam int RB_W      = $clog2(ROW_BYTES + 1);
    localparam int BPP_W     = $clog2(BYTES_PER_PIXEL + 1);
    localparam int SUM_W     = ROW_W + RB_W + 1;

    localparam logic [RB_W-1:0]  ROW_BYTES_C = RB_W'(ROW_BYTES);
    localparam logic [BPP_W-1:0] BPP_C       = BPP_W'(BYTES_PER_PIXEL);
    localparam logic [clr_pkg::HEIGHT_EXT_W-1:0] MAX_H_C =
        clr_pkg::HEIGHT_EXT_W'(MAX_HEIGHT);
    localparam logic [clr_pkg::COORD_W-1:0] WIDTH_C = clr_pkg::COORD_W'(FRAME_WIDTH);

    logic [clr_pkg::HEIGHT_EXT_W-1:0] h_ext, h_eff;
    logic [ROW_W-1:0]                 row;
    logic [COL_W-1:0]                 col;
    logic [SUM_W-1:0]                 row_off, col_off, sum;
    logic [clr_pkg::ADDR_W+SUM_W-1:0] sum_ext;

    always_comb begin
        // clipping height saturates at the largest supported frame
        h_ext    = clr_pkg::HEIGHT_EXT_W'(i_height);
        h_eff    = (h_ext > MAX_H_C) ? MAX_H_C : h_ext;
        o_inside = !i_x[clr_pkg::COORD_W-1] && !i_y[clr_pkg::COORD_W-1]
                && (clr_pkg::COORD_W'(i_x) < WIDTH_C)
                && (clr_pkg::COORD_W'(i_y) < clr_pkg::COORD_W'(h_eff));

        row     = i_y[ROW_W-1:0];
        col     = i_x[COL_W-1:0];
        row_off = SUM_W'(row) * SUM_W'(ROW_BYTES_C);
        col_off = SUM_W'(col) * SUM_W'(BPP_C);
        sum     = row_off + col_off;
        sum_ext = (clr_pkg::ADDR_W+SUM_W)'(sum);
        o_addr  = o_inside ? sum_ext[clr_pkg::ADDR_W-1:0] : '0;
    end

endmodule

### hw/rtl/clipped_line_rasterizer.sv
// clipped_line_rasterizer: Bresenham line drawer with frame clipping
// uses clr_pkg, clr_core and clr_pixel_addr
//
// Usage:
//   command channel (i_in_valid / o_in_stall / i_in): a load command takes
//   two signed endpoints and a color; each step command yields the next
//   pixel of the line. A transfer happens when valid is high and stall low.
//   result channel (o_out_valid / i_out_stall / o_out): one result per
//   command, in command order. Pixels outside the frame come back with
//   write_enable low; loads and steps with no active line come back idle.
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): frame height
//   used for clipping, always ready, to be written while no command is in
//   flight.
// Timing: the result is valid in the cycle after the command transfer. One
//   command per cycle is accepted, limited only by the result register while
//   a stalling receiver holds it: the step update and the address multiply
//   both sit between the line state and that register.
// Reset: no line is active, no result is pending and the frame height
//   returns to 1024 rows. While the receiver stalls, the held result stays
//   put and o_in_stall is raised, so no further command is taken.

module clipped_line_rasterizer #(
    parameter int FRAME_WIDTH     = clr_pkg::FRAME_WIDTH_DEF,
    parameter int BYTES_PER_PIXEL = clr_pkg::BYTES_PER_PIXEL_DEF,
    parameter int MAX_HEIGHT      = clr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  clr_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output clr_pkg::t_out                 o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [clr_pkg::HEIGHT_W-1:0]  i_cfg_data
);

    logic [clr_pkg::HEIGHT_W-1:0] r_height;
    logic                         r_out_valid, n_out_valid;
    clr_pkg::t_out                r_out, n_out;
    logic                         in_xfer;
    clr_pkg::t_pix                pix;
    logic                         pix_inside;
    logic [clr_pkg::ADDR_W-1:0]   addr;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_xfer     = i_in_valid && !o_in_stall;

    clr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_item   (i_in),
        .o_pix    (pix)
    );

    clr_pixel_addr #(
        .FRAME_WIDTH     (FRAME_WIDTH),
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
        .MAX_HEIGHT      (MAX_HEIGHT)
    ) u_addr (
        .i_x      (pix.x),
        .i_y      (pix.y),
        .i_height (r_height),
        .o_inside (pix_inside),
        .o_addr   (addr)
    );

    always_comb begin
        n_out.write_enable = pix.drawing && pix_inside;
        n_out.byte_address = pix.drawing ? addr : '0;
        n_out.pixel_red    = pix.drawing ? pix.color[23:16] : '0;
        n_out.pixel_green  = pix.drawing ? pix.color[15:8] : '0;
        n_out.pixel_blue   = pix.drawing ? pix.color[7:0] : '0;
        n_out.last_pixel   = pix.drawing && pix.last;
        n_out.idle         = !pix.drawing;

        if (in_xfer) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= clr_pkg::FRAME_HEIGHT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_height <= i_cfg_data;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.idle |-> !o_out.write_enable && !o_out.last_pixel
        && o_out.byte_address == '0)
        else $error("idle result carries a pixel");

    a_clip_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.write_enable |-> o_out.byte_address == '0)
        else $error("clipped pixel has a nonzero address");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !in_xfer)
        else $error("command taken while result is held");

endmodule
